FILE: hdl/spqt_pkg.sv
package spqt_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int KEY_WIDTH_DEF  = 32;
  localparam int PRIO_WIDTH_DEF = 16;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHANGE  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY       = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_LESS_URGENT = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL        = 3'd4;

  typedef struct packed {
    logic                load;      // latch key and prio of a new item
    logic                insert;
    logic                rm_head;
    logic                rm_sel;
    logic                search;
    logic                clear;
    logic                out_load;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic found;
    logic sel_gt;   // stored prio of the match is larger than the new one
    logic sel_lt;
  } sts_t;

endpackage

FILE: hdl/spqt_ctrl.sv
module spqt_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [spqt_pkg::OP_W-1:0] in_operation,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  spqt_pkg::sts_t            sts,
  output spqt_pkg::cmd_t            cmd
);
  import spqt_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_INSERT = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;
  logic                accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !rst_n ||
                     !((state_r == ST_IDLE) || ((state_r == ST_RESULT) && out_free));
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          op_nxt     = in_operation;
          status_nxt = STS_OK;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESULT;
        case (op_r)
          OP_ENQUEUE: begin
            if (sts.full) status_nxt = STS_FULL;
            else cmd.insert = 1'b1;
          end
          OP_DEQUEUE: begin
            if (sts.empty) status_nxt = STS_EMPTY;
            else cmd.rm_head = 1'b1;
          end
          OP_CHANGE: begin
            cmd.search = 1'b1;
            state_nxt  = ST_CHECK;
          end
          default: cmd.clear = 1'b1;
        endcase
      end
      ST_CHECK: begin
        state_nxt = ST_RESULT;
        if (!sts.found) begin
          status_nxt = STS_NOT_FOUND;
        end else if (sts.sel_gt) begin
          // pull the match out, then put it back at its new place
          cmd.rm_sel = 1'b1;
          state_nxt  = ST_INSERT;
        end else if (sts.sel_lt) begin
          status_nxt = STS_LESS_URGENT;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
          if (accept) begin
            cmd.load   = 1'b1;
            op_nxt     = in_operation;
            status_nxt = STS_OK;
            state_nxt  = ST_EXEC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
  end

endmodule

FILE: hdl/spqt_dpath.sv
module spqt_dpath #(
  parameter int DEPTH      = spqt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH  = spqt_pkg::KEY_WIDTH_DEF,
  parameter int PRIO_WIDTH = spqt_pkg::PRIO_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spqt_pkg::cmd_t                cmd,
  input  logic [KEY_WIDTH-1:0]          in_key,
  input  logic signed [PRIO_WIDTH-1:0]  in_prio,
  output spqt_pkg::sts_t                sts,
  output logic [spqt_pkg::STATUS_W-1:0] out_status,
  output logic [KEY_WIDTH-1:0]          out_taken_key,
  output logic signed [PRIO_WIDTH-1:0]  out_taken_prio,
  output logic [KEY_WIDTH-1:0]          out_head_key,
  output logic signed [PRIO_WIDTH-1:0]  out_head_prio,
  output logic                          out_is_empty,
  output logic [CNT_W-1:0]              out_entry_count
);
  import spqt_pkg::*;

  logic [KEY_WIDTH-1:0]         key_r   [DEPTH];
  logic [KEY_WIDTH-1:0]         key_nxt [DEPTH];
  logic signed [PRIO_WIDTH-1:0] prio_r   [DEPTH];
  logic signed [PRIO_WIDTH-1:0] prio_nxt [DEPTH];
  logic [CNT_W-1:0]             count_r, count_nxt;

  logic [KEY_WIDTH-1:0]         item_key_r;
  logic signed [PRIO_WIDTH-1:0] item_prio_r;
  logic [KEY_WIDTH-1:0]         taken_key_r;
  logic signed [PRIO_WIDTH-1:0] taken_prio_r;

  logic [DEPTH-1:0]             goes_before;
  logic [DEPTH-1:0]             hit;
  logic [DEPTH-1:0]             first_hit;
  logic [DEPTH-1:0]             sel_r;
  logic [DEPTH-1:0]             rm_mask;
  logic signed [PRIO_WIDTH-1:0] sel_prio;
  logic                         found_r, sel_gt_r, sel_lt_r;
  logic                         removing;

  logic [STATUS_W-1:0]          out_status_r;
  logic [KEY_WIDTH-1:0]         out_taken_key_r, out_head_key_r;
  logic signed [PRIO_WIDTH-1:0] out_taken_prio_r, out_head_prio_r;
  logic                         out_is_empty_r;
  logic [CNT_W-1:0]             out_entry_count_r;

  assign removing = cmd.rm_head || cmd.rm_sel;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         valid;
    logic                         prev_before;
    logic                         from_above;
    logic [KEY_WIDTH-1:0]         key_lo, key_hi;
    logic signed [PRIO_WIDTH-1:0] prio_lo, prio_hi;

    assign valid = CNT_W'(i) < count_r;
    // free slots count as "goes before", so the insert point is the first set bit
    assign goes_before[i] = !valid || (prio_r[i] > item_prio_r) ||
                            ((prio_r[i] == item_prio_r) && (item_key_r > key_r[i]));
    // the port may already carry the next item, so match on the latched key
    assign hit[i]       = valid && (key_r[i] == item_key_r);
    assign first_hit[i] = hit[i] && !(|(hit & ({DEPTH{1'b1}} >> (DEPTH - i))));
    assign from_above   = |(sel_r & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
    assign rm_mask[i]   = cmd.rm_head || from_above;

    if (i == 0) begin : g_first
      assign prev_before = 1'b0;
      assign key_lo      = '0;
      assign prio_lo     = '0;
    end else begin : g_rest
      assign prev_before = goes_before[i-1];
      assign key_lo      = key_r[i-1];
      assign prio_lo     = prio_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign key_hi  = '0;
      assign prio_hi = '0;
    end else begin : g_inner
      assign key_hi  = key_r[i+1];
      assign prio_hi = prio_r[i+1];
    end

    always_comb begin
      key_nxt[i]  = key_r[i];
      prio_nxt[i] = prio_r[i];
      if (cmd.insert) begin
        if (prev_before) begin
          key_nxt[i]  = key_lo;
          prio_nxt[i] = prio_lo;
        end else if (goes_before[i]) begin
          key_nxt[i]  = item_key_r;
          prio_nxt[i] = item_prio_r;
        end
      end else if (removing && rm_mask[i]) begin
        key_nxt[i]  = key_hi;
        prio_nxt[i] = prio_hi;
      end
    end
  end

  always_comb begin
    sel_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hit[i]) sel_prio = prio_r[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) count_nxt = '0;
    else if (cmd.insert) count_nxt = count_r + CNT_W'(1);
    else if (removing) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      key_r[i]  <= key_nxt[i];
      prio_r[i] <= prio_nxt[i];
    end
    if (cmd.load) begin
      item_key_r   <= in_key;
      item_prio_r  <= in_prio;
      taken_key_r  <= '0;
      taken_prio_r <= '0;
    end else if (cmd.rm_head) begin
      taken_key_r  <= key_r[0];
      taken_prio_r <= prio_r[0];
    end
    if (cmd.search) begin
      sel_r    <= first_hit;
      found_r  <= |first_hit;
      sel_gt_r <= sel_prio > item_prio_r;
      sel_lt_r <= sel_prio < item_prio_r;
    end else if (cmd.rm_sel) begin
      sel_r <= '0;
    end else if (cmd.load) begin
      sel_r <= '0;
    end
    if (cmd.out_load) begin
      out_status_r      <= cmd.status;
      out_taken_key_r   <= taken_key_r;
      out_taken_prio_r  <= taken_prio_r;
      out_head_key_r    <= (count_r != '0) ? key_r[0] : '0;
      out_head_prio_r   <= (count_r != '0) ? prio_r[0] : '0;
      out_is_empty_r    <= (count_r == '0);
      out_entry_count_r <= count_r;
    end
  end

  assign sts.full   = (count_r == CNT_W'(DEPTH));
  assign sts.empty  = (count_r == '0);
  assign sts.found  = found_r;
  assign sts.sel_gt = sel_gt_r;
  assign sts.sel_lt = sel_lt_r;

  assign out_status      = out_status_r;
  assign out_taken_key   = out_taken_key_r;
  assign out_taken_prio  = out_taken_prio_r;
  assign out_head_key    = out_head_key_r;
  assign out_head_prio   = out_head_prio_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_entry_count = out_entry_count_r;

endmodule

FILE: hdl/sorted_priority_queue_table.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   in_operation, in_key, in_prio
// out_     output     out_valid / out_stall status, taken item, head, empty flag, count
//
// Enqueue, dequeue and clear each make one pass over the table; change priority
// makes a search pass and, when the entry moves, a remove pass and an insert
// pass. In each pass every slot of the register table compares and shifts at once.
// rst_n is synchronous: it empties the table and drops any pending result.
// A new item is taken while a finished result waits; the next result holds
// until out_stall falls.
module sorted_priority_queue_table #(
  parameter int DEPTH      = spqt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH  = spqt_pkg::KEY_WIDTH_DEF,
  parameter int PRIO_WIDTH = spqt_pkg::PRIO_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spqt_pkg::OP_W-1:0]     in_operation,
  input  logic [KEY_WIDTH-1:0]          in_key,
  input  logic signed [PRIO_WIDTH-1:0]  in_prio,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spqt_pkg::STATUS_W-1:0] out_status,
  output logic [KEY_WIDTH-1:0]          out_taken_key,
  output logic signed [PRIO_WIDTH-1:0]  out_taken_prio,
  output logic [KEY_WIDTH-1:0]          out_head_key,
  output logic signed [PRIO_WIDTH-1:0]  out_head_prio,
  output logic                          out_is_empty,
  output logic [CNT_W-1:0]              out_entry_count
);
  import spqt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spqt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  spqt_dpath #(
    .DEPTH      (DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH),
    .CNT_W      (CNT_W)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_key          (in_key),
    .in_prio         (in_prio),
    .sts             (sts),
    .out_status      (out_status),
    .out_taken_key   (out_taken_key),
    .out_taken_prio  (out_taken_prio),
    .out_head_key    (out_head_key),
    .out_head_prio   (out_head_prio),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_W'(DEPTH)))
    else $error("entry count above depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_FULL)) |-> (out_entry_count == CNT_W'(DEPTH)))
    else $error("full status on a table that is not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_EMPTY)) |-> (out_is_empty && (out_taken_key == '0)))
    else $error("empty status with entries or a taken item");

endmodule
